// ===== design/fixed_point_pid_with_filters_defines.svh =====
// Assertion helpers used by the module that checks itself.
// Both forms sample on clk and are disabled while rst_n is low.
`ifndef FIXED_POINT_PID_WITH_FILTERS_DEFINES_SVH
`define FIXED_POINT_PID_WITH_FILTERS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FPID_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FPID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/fpid_pkg.sv =====
package fpid_pkg;

  // Q16.16 scaling.
  localparam int QSHIFT = 16;
  localparam int QONE   = 65536;

  // Operand and product widths of the shared multiplier.
  localparam int MW_BITS = 33;
  localparam int PW_BITS = 2 * MW_BITS;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_FF_GAIN   = 3'd0,
    REG_P_GAIN    = 3'd1,
    REG_I_GAIN    = 3'd2,
    REG_D_GAIN    = 3'd3,
    REG_DRIVE_LO  = 3'd4,
    REG_DRIVE_HI  = 3'd5,
    REG_INTEG_LO  = 3'd6,
    REG_INTEG_HI  = 3'd7
  } cfg_reg_t;

  // One request to the shared multiplier. Operands are two's complement.
  typedef struct packed {
    logic               en;
    logic [MW_BITS-1:0] a;
    logic [MW_BITS-1:0] b;
  } mul_req_t;

endpackage

// ===== design/fpid_mul.sv =====
module fpid_mul (
  input  logic                             clk,
  input  fpid_pkg::mul_req_t               req,
  output logic signed [fpid_pkg::PW_BITS-1:0] prod
);

  logic signed [fpid_pkg::PW_BITS-1:0] prod_r;
  logic signed [fpid_pkg::PW_BITS-1:0] prod_nxt;

  // The product holds while no request is issued.
  always_comb begin
    prod_nxt = prod_r;
    if (req.en) begin
      prod_nxt = signed'(req.a) * signed'(req.b);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

// ===== design/fixed_point_pid_with_filters.sv =====
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   in_measurement, in_target, in_clear_integral
// out       output     out_valid / out_stall out_drive
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// After acceptance a word passes the input filter if the measurement alpha is nonzero, the
// feed-forward, P and I terms, the derivative term if the derivative gain is nonzero (smoothed
// first if the derivative alpha is nonzero), the drive clamp and the drive filter if its alpha
// is nonzero, then is loaded; every product goes through the one 33 x 33 multiplier in turn.
// Reset is synchronous and active low and restores the register defaults and the history.
// in_stall is high while the sequencer is busy; a finished word may wait in the output
// register while the next one is computed, and only the next load waits for it to drain.

`include "fixed_point_pid_with_filters_defines.svh"

module fixed_point_pid_with_filters #(
  parameter int unsigned MEAS_ALPHA   = 0,
  parameter int unsigned DERIV_ALPHA  = 0,
  parameter int unsigned DRIVE_ALPHA  = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  // Measurement words.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_measurement,
  input  logic signed [15:0] in_target,
  input  logic               in_clear_integral,
  // Drive words.
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_drive,
  // Register writes.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int MW = fpid_pkg::MW_BITS;
  localparam int PW = fpid_pkg::PW_BITS;
  // The sum of the four terms stays well inside this width.
  localparam int SW = 52;
  localparam int QS = fpid_pkg::QSHIFT;

  // Filter weights as multiplier operands: alpha and its complement to one.
  localparam logic [MW-1:0] IN_W   = MW'(MEAS_ALPHA);
  localparam logic [MW-1:0] IN_WC  = MW'(fpid_pkg::QONE - MEAS_ALPHA);
  localparam logic [MW-1:0] DER_W  = MW'(DERIV_ALPHA);
  localparam logic [MW-1:0] DER_WC = MW'(fpid_pkg::QONE - DERIV_ALPHA);
  localparam logic [MW-1:0] OUT_W  = MW'(DRIVE_ALPHA);
  localparam logic [MW-1:0] OUT_WC = MW'(fpid_pkg::QONE - DRIVE_ALPHA);

  // Sequencer states. Each state issues at most one product, which the
  // following state consumes.
  typedef enum logic [17:0] {
    ST_IDLE  = 18'h00001,
    ST_XA    = 18'h00002,
    ST_XB    = 18'h00004,
    ST_XC    = 18'h00008,
    ST_FF    = 18'h00010,
    ST_P     = 18'h00020,
    ST_I     = 18'h00040,
    ST_IC    = 18'h00080,
    ST_ADDI  = 18'h00100,
    ST_DA    = 18'h00200,
    ST_DB    = 18'h00400,
    ST_DC    = 18'h00800,
    ST_DM    = 18'h01000,
    ST_DADD  = 18'h02000,
    ST_CLAMP = 18'h04000,
    ST_OA    = 18'h08000,
    ST_OB    = 18'h10000,
    ST_OC    = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic signed [31:0] ff_r, ff_nxt;
  logic signed [31:0] pg_r, pg_nxt;
  logic signed [31:0] ig_r, ig_nxt;
  logic signed [31:0] dg_r, dg_nxt;
  logic signed [15:0] dlo_r, dlo_nxt;
  logic signed [15:0] dhi_r, dhi_nxt;
  logic signed [15:0] ilo_r, ilo_nxt;
  logic signed [15:0] ihi_r, ihi_nxt;

  // Controller history. Every value fits in at most 33 bits.
  logic signed [31:0] fi_r, fi_nxt;
  logic signed [31:0] integ_r, integ_nxt;
  logic signed [32:0] df_r, df_nxt;
  logic signed [15:0] last_r, last_nxt;

  // Working registers of one step.
  logic signed [15:0]    m_r, m_nxt;
  logic signed [15:0]    s_r, s_nxt;
  logic signed [31:0]    x_r, x_nxt;
  logic signed [32:0]    e_r, e_nxt;
  logic signed [32:0]    r_r, r_nxt;
  logic signed [SW-1:0]  sum_r, sum_nxt;
  logic signed [PW-1:0]  acc_r, acc_nxt;
  logic signed [15:0]    y_r, y_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic signed [15:0]    out_drive_r, out_drive_nxt;

  fpid_pkg::mul_req_t    mul_req;
  logic signed [PW-1:0]  prod;
  logic signed [PW-1:0]  prod_sh;
  logic signed [SW-1:0]  prod_lo;
  logic signed [SW-1:0]  prod_sh_lo;
  logic signed [PW-1:0]  blend_sum;
  logic signed [PW-1:0]  blend_q;

  logic signed [SW-1:0]  integ_w;
  logic signed [SW-1:0]  ilo_w;
  logic signed [SW-1:0]  ihi_w;
  logic signed [31:0]    ilo_q;
  logic signed [31:0]    ihi_q;
  logic signed [31:0]    integ_clamped;
  logic signed [SW-1:0]  sum_sh;
  logic signed [SW-1:0]  dlo_w;
  logic signed [SW-1:0]  dhi_w;
  logic signed [15:0]    y_clamped;
  logic                  out_free;
  logic                  in_accept;

  fpid_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Products are floored by an arithmetic shift. The second half of every
  // blend lands in prod while the first half waits in acc_r.
  assign prod_sh    = prod >>> QS;
  assign prod_lo    = prod[SW-1:0];
  assign prod_sh_lo = prod_sh[SW-1:0];
  assign blend_sum  = acc_r + prod;
  assign blend_q    = blend_sum >>> QS;

  // Integral update and clamp. The low limit is tested first, so crossed
  // limits resolve toward the low limit below it and the high one above.
  assign ilo_q   = {ilo_r, 16'h0000};
  assign ihi_q   = {ihi_r, 16'h0000};
  assign ilo_w   = {{(SW-32){ilo_r[15]}}, ilo_r, 16'h0000};
  assign ihi_w   = {{(SW-32){ihi_r[15]}}, ihi_r, 16'h0000};
  assign integ_w = {{(SW-32){integ_r[31]}}, integ_r} + prod_sh_lo;

  always_comb begin
    if (integ_w < ilo_w) begin
      integ_clamped = ilo_q;
    end else if (integ_w > ihi_w) begin
      integ_clamped = ihi_q;
    end else begin
      integ_clamped = integ_w[31:0];
    end
  end

  // Drive clamp, with the same ordering as the integral clamp.
  assign sum_sh = sum_r >>> QS;
  assign dlo_w  = {{(SW-16){dlo_r[15]}}, dlo_r};
  assign dhi_w  = {{(SW-16){dhi_r[15]}}, dhi_r};

  always_comb begin
    if (sum_sh < dlo_w) begin
      y_clamped = dlo_r;
    end else if (sum_sh > dhi_w) begin
      y_clamped = dhi_r;
    end else begin
      y_clamped = sum_sh[15:0];
    end
  end

  // Register writes are to be issued only while the block is idle; the block itself does not enforce this.
  assign cfg_ready = 1'b1;

  always_comb begin
    ff_nxt  = ff_r;
    pg_nxt  = pg_r;
    ig_nxt  = ig_r;
    dg_nxt  = dg_r;
    dlo_nxt = dlo_r;
    dhi_nxt = dhi_r;
    ilo_nxt = ilo_r;
    ihi_nxt = ihi_r;
    if (cfg_valid && cfg_ready) begin
      case (fpid_pkg::cfg_reg_t'(cfg_index))
        fpid_pkg::REG_FF_GAIN:  ff_nxt  = cfg_data;
        fpid_pkg::REG_P_GAIN:   pg_nxt  = cfg_data;
        fpid_pkg::REG_I_GAIN:   ig_nxt  = cfg_data;
        fpid_pkg::REG_D_GAIN:   dg_nxt  = cfg_data;
        fpid_pkg::REG_DRIVE_LO: dlo_nxt = cfg_data[15:0];
        fpid_pkg::REG_DRIVE_HI: dhi_nxt = cfg_data[15:0];
        fpid_pkg::REG_INTEG_LO: ilo_nxt = cfg_data[15:0];
        fpid_pkg::REG_INTEG_HI: ihi_nxt = cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    fi_nxt        = fi_r;
    integ_nxt     = integ_r;
    df_nxt        = df_r;
    last_nxt      = last_r;
    m_nxt         = m_r;
    s_nxt         = s_r;
    x_nxt         = x_r;
    e_nxt         = e_r;
    r_nxt         = r_r;
    sum_nxt       = sum_r;
    acc_nxt       = acc_r;
    y_nxt         = y_r;
    out_drive_nxt = out_drive_r;
    out_valid_nxt = out_valid_r && out_stall;
    mul_req       = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          m_nxt = in_measurement;
          s_nxt = in_target;
          if (in_clear_integral) begin
            integ_nxt = '0;
          end
          if (MEAS_ALPHA == 0) begin
            x_nxt     = {in_measurement, 16'h0000};
            state_nxt = ST_FF;
          end else begin
            state_nxt = ST_XA;
          end
        end
      end

      // Input filter: blend of the new sample and the previous filtered value.
      ST_XA: begin
        mul_req.en = 1'b1;
        mul_req.a  = IN_W;
        mul_req.b  = {{(MW-32){m_r[15]}}, m_r, 16'h0000};
        state_nxt  = ST_XB;
      end
      ST_XB: begin
        acc_nxt    = prod;
        mul_req.en = 1'b1;
        mul_req.a  = IN_WC;
        mul_req.b  = {{(MW-32){fi_r[31]}}, fi_r};
        state_nxt  = ST_XC;
      end
      ST_XC: begin
        x_nxt     = blend_q[31:0];
        state_nxt = ST_FF;
      end

      // Feed-forward product; the target is taken in integer units, so the
      // product is already the Q16.16 term.
      ST_FF: begin
        mul_req.en = 1'b1;
        mul_req.a  = {{(MW-32){ff_r[31]}}, ff_r};
        mul_req.b  = {{(MW-16){s_r[15]}}, s_r};
        e_nxt      = {s_r[15], s_r, 16'h0000} - {x_r[31], x_r};
        state_nxt  = ST_P;
      end
      ST_P: begin
        sum_nxt    = prod_lo;
        mul_req.en = 1'b1;
        mul_req.a  = {{(MW-32){pg_r[31]}}, pg_r};
        mul_req.b  = e_r;
        state_nxt  = ST_I;
      end
      ST_I: begin
        sum_nxt    = sum_r + prod_sh_lo;
        mul_req.en = 1'b1;
        mul_req.a  = {{(MW-32){ig_r[31]}}, ig_r};
        mul_req.b  = e_r;
        state_nxt  = ST_IC;
      end
      ST_IC: begin
        integ_nxt = integ_clamped;
        r_nxt     = {fi_r[31], fi_r} - {x_r[31], x_r};
        state_nxt = ST_ADDI;
      end
      ST_ADDI: begin
        sum_nxt = sum_r + {{(SW-32){integ_r[31]}}, integ_r};
        fi_nxt  = x_r;
        if (dg_r != '0) begin
          state_nxt = ST_DA;
        end else begin
          state_nxt = ST_CLAMP;
        end
      end

      // Derivative on the measurement, optionally smoothed.
      ST_DA: begin
        if (DERIV_ALPHA == 0) begin
          df_nxt    = r_r;
          state_nxt = ST_DM;
        end else begin
          mul_req.en = 1'b1;
          mul_req.a  = DER_W;
          mul_req.b  = r_r;
          state_nxt  = ST_DB;
        end
      end
      ST_DB: begin
        acc_nxt    = prod;
        mul_req.en = 1'b1;
        mul_req.a  = DER_WC;
        mul_req.b  = df_r;
        state_nxt  = ST_DC;
      end
      ST_DC: begin
        df_nxt    = blend_q[32:0];
        state_nxt = ST_DM;
      end
      ST_DM: begin
        mul_req.en = 1'b1;
        mul_req.a  = {{(MW-32){dg_r[31]}}, dg_r};
        mul_req.b  = df_r;
        state_nxt  = ST_DADD;
      end
      ST_DADD: begin
        sum_nxt   = sum_r + prod_sh_lo;
        state_nxt = ST_CLAMP;
      end

      // Clamp to the drive limits; without output smoothing the result is
      // loaded here as soon as the output register is free.
      ST_CLAMP: begin
        if (DRIVE_ALPHA == 0) begin
          if (out_free) begin
            last_nxt      = y_clamped;
            out_drive_nxt = y_clamped;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          y_nxt     = y_clamped;
          state_nxt = ST_OA;
        end
      end

      // Output smoothing weights the previous drive by alpha.
      ST_OA: begin
        mul_req.en = 1'b1;
        mul_req.a  = OUT_W;
        mul_req.b  = {{(MW-16){last_r[15]}}, last_r};
        state_nxt  = ST_OB;
      end
      ST_OB: begin
        acc_nxt    = prod;
        mul_req.en = 1'b1;
        mul_req.a  = OUT_WC;
        mul_req.b  = {{(MW-16){y_r[15]}}, y_r};
        state_nxt  = ST_OC;
      end
      ST_OC: begin
        if (out_free) begin
          last_nxt      = blend_q[15:0];
          out_drive_nxt = blend_q[15:0];
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control, configuration and history registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ff_r        <= '0;
      pg_r        <= '0;
      ig_r        <= '0;
      dg_r        <= '0;
      dlo_r       <= 16'sh8000;
      dhi_r       <= 16'sh7fff;
      ilo_r       <= 16'sh8000;
      ihi_r       <= 16'sh7fff;
      fi_r        <= '0;
      integ_r     <= '0;
      df_r        <= '0;
      last_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ff_r        <= ff_nxt;
      pg_r        <= pg_nxt;
      ig_r        <= ig_nxt;
      dg_r        <= dg_nxt;
      dlo_r       <= dlo_nxt;
      dhi_r       <= dhi_nxt;
      ilo_r       <= ilo_nxt;
      ihi_r       <= ihi_nxt;
      fi_r        <= fi_nxt;
      integ_r     <= integ_nxt;
      df_r        <= df_nxt;
      last_r      <= last_nxt;
    end
  end

  // Working values of the current step.
  always_ff @(posedge clk) begin
    m_r         <= m_nxt;
    s_r         <= s_nxt;
    x_r         <= x_nxt;
    e_r         <= e_nxt;
    r_r         <= r_nxt;
    sum_r       <= sum_nxt;
    acc_r       <= acc_nxt;
    y_r         <= y_nxt;
    out_drive_r <= out_drive_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

  `FPID_ASSERT_NEXT(a_accept_starts_step, in_accept, state_r != ST_IDLE, "accepted word did not start a step")
  `FPID_ASSERT_HOLDS(a_integ_in_limits, (state_r == ST_ADDI) && (ilo_r <= ihi_r), (integ_r >= ilo_q) && (integ_r <= ihi_q), "integral outside its limits")
  `FPID_ASSERT_HOLDS(a_out_from_load, $rose(out_valid_r), ($past(state_r) == ST_CLAMP) || ($past(state_r) == ST_OC), "drive word raised outside a load state")
  `FPID_ASSERT_HOLDS(a_df_written_in_deriv, $past(rst_n) && !$stable(df_r), ($past(state_r) == ST_DA) || ($past(state_r) == ST_DC), "derivative history changed outside the derivative states")

endmodule
